>>> design/pim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pim_pkg
// Types and constants shared by the priority inheritance mutex and its checker.
// ----------------------------------------------------------------------------
package pim_pkg;

  localparam int TASKS  = 8;
  localparam int TASK_W = 3;
  localparam int PRIO_W = 8;
  localparam int TICK_W = 32;
  localparam int IDX_W  = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CNT_W  = $clog2(TASKS + 1);

  typedef enum logic [1:0] {
    FUNC_LOCK   = 2'd0,
    FUNC_UNLOCK = 2'd1,
    FUNC_EXPIRE = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_ACQUIRED   = 4'd0,
    ST_OWNER      = 4'd1,
    ST_REFUSED    = 4'd2,
    ST_QUEUED     = 4'd3,
    ST_IGNORED    = 4'd4,
    ST_RELEASED   = 4'd5,
    ST_HANDED     = 4'd6,
    ST_REMOVED    = 4'd7,
    ST_NO_WAITER  = 4'd8
  } status_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [TASK_W-1:0] task_req;
    logic [PRIO_W-1:0] requester_priority;
    logic [PRIO_W-1:0] base_priority;
    logic [TICK_W-1:0] timeout;
  } req_t;

  typedef struct packed {
    logic [3:0]        status;
    logic              owner_valid;
    logic [TASK_W-1:0] owner_now;
    logic              prio_write;
    logic [TASK_W-1:0] prio_task;
    logic [PRIO_W-1:0] prio_value;
    logic              woken_valid;
    logic [TASK_W-1:0] woken_task;
    logic [TICK_W-1:0] wait_ticks;
    logic              switch_request;
  } rsp_t;

endpackage : pim_pkg
`default_nettype wire

>>> design/priority_inheritance_mutex.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_inheritance_mutex
// Hardware mutex with priority inheritance. Every request but an owner's
// unlock finishes in the cycle it is accepted, and its response is in the
// output register in the cycle after. An unlock by the owner walks the waiter
// priority memory one entry per cycle through its single read port and its
// response is registered once the output register is free; handover goes to
// the most urgent waiter, ties to the lowest task number. A new request is
// taken once the block is idle and the output register is empty or being drained.
// ----------------------------------------------------------------------------
module priority_inheritance_mutex (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pim_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pim_pkg::rsp_t      out_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                         state_r, state_nxt;
  logic                           lock_held_r, lock_held_nxt;
  logic [pim_pkg::TASK_W-1:0]     owner_id_r, owner_id_nxt;
  logic [pim_pkg::PRIO_W-1:0]     owner_prio_r, owner_prio_nxt;
  logic [pim_pkg::TASKS-1:0]      wait_mask_r, wait_mask_nxt;

  logic                           out_valid_r, out_valid_nxt;
  pim_pkg::rsp_t                  out_data_r, out_data_nxt;

  // unlock scan
  logic [pim_pkg::CNT_W-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic                           rd_pend_r, rd_pend_nxt;
  logic [pim_pkg::IDX_W-1:0]      rd_tag_r, rd_tag_nxt;
  logic                           found_r, found_nxt;
  logic [pim_pkg::IDX_W-1:0]      best_r, best_nxt;
  logic [pim_pkg::PRIO_W-1:0]     bestp_r, bestp_nxt;
  logic [pim_pkg::TASK_W-1:0]     rel_task_r, rel_task_nxt;
  logic [pim_pkg::PRIO_W-1:0]     rel_base_r, rel_base_nxt;

  // waiter priority memory
  logic [pim_pkg::PRIO_W-1:0]     wprio_mem [pim_pkg::TASKS];
  logic                           mem_we;
  logic [pim_pkg::IDX_W-1:0]      mem_waddr;
  logic [pim_pkg::PRIO_W-1:0]     mem_wdata;
  logic                           mem_re;
  logic [pim_pkg::IDX_W-1:0]      mem_raddr;
  logic [pim_pkg::PRIO_W-1:0]     mem_rdata_r;

  logic                           out_free;
  logic                           accept;
  logic                           task_ok;
  logic [pim_pkg::IDX_W-1:0]      req_idx;
  logic                           is_waiting;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign task_ok    = int'(in_data.task_req) < pim_pkg::TASKS;
  assign req_idx    = pim_pkg::IDX_W'(in_data.task_req);
  assign is_waiting = task_ok && wait_mask_r[req_idx];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wprio_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= wprio_mem[mem_raddr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    lock_held_nxt  = lock_held_r;
    owner_id_nxt   = owner_id_r;
    owner_prio_nxt = owner_prio_r;
    wait_mask_nxt  = wait_mask_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    rd_cnt_nxt     = rd_cnt_r;
    rd_pend_nxt    = 1'b0;
    rd_tag_nxt     = rd_tag_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    bestp_nxt      = bestp_r;
    rel_task_nxt   = rel_task_r;
    rel_base_nxt   = rel_base_r;
    mem_we         = 1'b0;
    mem_waddr      = req_idx;
    mem_wdata      = in_data.requester_priority;
    mem_re         = 1'b0;
    mem_raddr      = rd_cnt_r[pim_pkg::IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt        = '0;
          out_data_nxt.status = pim_pkg::ST_IGNORED;
          out_valid_nxt       = 1'b1;
          case (in_data.func)
            pim_pkg::FUNC_LOCK: begin
              if (!task_ok) begin
                out_data_nxt.status = pim_pkg::ST_REFUSED;
              end else if (!lock_held_r) begin
                lock_held_nxt       = 1'b1;
                owner_id_nxt        = in_data.task_req;
                owner_prio_nxt      = in_data.requester_priority;
                out_data_nxt.status = pim_pkg::ST_ACQUIRED;
              end else if (owner_id_r == in_data.task_req) begin
                out_data_nxt.status = pim_pkg::ST_OWNER;
              end else if (in_data.timeout == '0) begin
                out_data_nxt.status = pim_pkg::ST_REFUSED;
              end else begin
                if (in_data.requester_priority < owner_prio_r) begin
                  owner_prio_nxt          = in_data.requester_priority;
                  out_data_nxt.prio_write = 1'b1;
                  out_data_nxt.prio_task  = owner_id_r;
                  out_data_nxt.prio_value = in_data.requester_priority;
                end
                wait_mask_nxt[req_idx]      = 1'b1;
                mem_we                      = 1'b1;
                out_data_nxt.wait_ticks     = in_data.timeout;
                out_data_nxt.switch_request = 1'b1;
                out_data_nxt.status         = pim_pkg::ST_QUEUED;
              end
            end
            pim_pkg::FUNC_UNLOCK: begin
              if (task_ok && lock_held_r && owner_id_r == in_data.task_req) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_SCAN;
                rd_cnt_nxt    = '0;
                found_nxt     = 1'b0;
                rel_task_nxt  = in_data.task_req;
                rel_base_nxt  = in_data.base_priority;
              end
            end
            pim_pkg::FUNC_EXPIRE: begin
              if (is_waiting) begin
                wait_mask_nxt[req_idx] = 1'b0;
                out_data_nxt.status    = pim_pkg::ST_REMOVED;
              end else begin
                out_data_nxt.status    = pim_pkg::ST_NO_WAITER;
              end
            end
            default: begin
              out_data_nxt.status = pim_pkg::ST_IGNORED;
            end
          endcase
          out_data_nxt.owner_valid = lock_held_nxt;
          out_data_nxt.owner_now   = lock_held_nxt ? owner_id_nxt : '0;
        end
      end

      S_SCAN: begin
        if (int'(rd_cnt_r) < pim_pkg::TASKS) begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_tag_nxt  = rd_cnt_r[pim_pkg::IDX_W-1:0];
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
        end
        if (rd_pend_r) begin
          if (wait_mask_r[rd_tag_r] && (!found_r || mem_rdata_r < bestp_r)) begin
            found_nxt = 1'b1;
            best_nxt  = rd_tag_r;
            bestp_nxt = mem_rdata_r;
          end
          if (int'(rd_tag_r) == pim_pkg::TASKS - 1) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt               = S_IDLE;
          out_valid_nxt           = 1'b1;
          out_data_nxt            = '0;
          out_data_nxt.prio_write = 1'b1;
          out_data_nxt.prio_task  = rel_task_r;
          out_data_nxt.prio_value = rel_base_r;
          if (found_r) begin
            wait_mask_nxt[best_r]       = 1'b0;
            lock_held_nxt               = 1'b1;
            owner_id_nxt                = pim_pkg::TASK_W'(best_r);
            owner_prio_nxt              = bestp_r;
            out_data_nxt.status         = pim_pkg::ST_HANDED;
            out_data_nxt.owner_valid    = 1'b1;
            out_data_nxt.owner_now      = pim_pkg::TASK_W'(best_r);
            out_data_nxt.woken_valid    = 1'b1;
            out_data_nxt.woken_task     = pim_pkg::TASK_W'(best_r);
            out_data_nxt.switch_request = 1'b1;
          end else begin
            lock_held_nxt       = 1'b0;
            owner_id_nxt        = '0;
            out_data_nxt.status = pim_pkg::ST_RELEASED;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lock_held_r  <= 1'b0;
      owner_id_r   <= '0;
      owner_prio_r <= '0;
      wait_mask_r  <= '0;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      rd_cnt_r     <= '0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lock_held_r  <= lock_held_nxt;
      owner_id_r   <= owner_id_nxt;
      owner_prio_r <= owner_prio_nxt;
      wait_mask_r  <= wait_mask_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_pend_r    <= rd_pend_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      found_r      <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    rd_tag_r   <= rd_tag_nxt;
    best_r     <= best_nxt;
    bestp_r    <= bestp_nxt;
    rel_task_r <= rel_task_nxt;
    rel_base_r <= rel_base_nxt;
  end

endmodule : priority_inheritance_mutex
`default_nettype wire

>>> design/pim_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pim_checker
// Port-level checks on the priority inheritance mutex responses.
// ----------------------------------------------------------------------------
module pim_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire pim_pkg::rsp_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled response changed");

  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.woken_valid |->
      out_data.owner_valid && out_data.owner_now == out_data.woken_task &&
      out_data.status == pim_pkg::ST_HANDED && out_data.switch_request)
    else $error("handover response inconsistent");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == pim_pkg::ST_RELEASED |->
      !out_data.owner_valid && out_data.prio_write && !out_data.woken_valid)
    else $error("release response inconsistent");

  a_queued: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == pim_pkg::ST_QUEUED |->
      out_data.switch_request && out_data.owner_valid &&
      out_data.wait_ticks != '0)
    else $error("queued response inconsistent");

endmodule : pim_checker

bind priority_inheritance_mutex pim_checker u_pim_checker (.*);
`default_nettype wire

>>> bench/priority_inheritance_mutex_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_inheritance_mutex_tb
// Self-checking bench for the priority inheritance mutex. A scoreboard class
// tracks owner, boosted priority and the wait set, predicts every response
// and compares it field by field. Directed lock, unlock and expiry sequences
// come first, then random traffic that mostly follows legal ownership, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module priority_inheritance_mutex_tb;
  import pim_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int ITEMS = 950;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE = 30;

  class mutex_scoreboard;
    logic              held;
    logic [TASK_W-1:0] owner;
    logic [PRIO_W-1:0] owner_prio;
    logic [TASKS-1:0]  waiting;
    logic [PRIO_W-1:0] waiter_prio [TASKS];
    rsp_t              expected_q [$];
    int                errors;

    function new();
      held = 1'b0;
      owner = '0;
      owner_prio = '0;
      waiting = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(req_t r);
      rsp_t              e;
      logic              found;
      logic [TASK_W-1:0] best;
      logic [PRIO_W-1:0] best_prio;
      e = '0;
      e.status = ST_IGNORED;
      found = 1'b0;
      best = '0;
      best_prio = '0;
      case (r.func)
        FUNC_LOCK: begin
          if (!held) begin
            held = 1'b1;
            owner = r.task_req;
            owner_prio = r.requester_priority;
            e.status = ST_ACQUIRED;
          end else if (owner == r.task_req) begin
            e.status = ST_OWNER;
          end else if (r.timeout == '0) begin
            e.status = ST_REFUSED;
          end else begin
            if (r.requester_priority < owner_prio) begin
              owner_prio = r.requester_priority;
              e.prio_write = 1'b1;
              e.prio_task = owner;
              e.prio_value = r.requester_priority;
            end
            waiting[r.task_req] = 1'b1;
            waiter_prio[r.task_req] = r.requester_priority;
            e.wait_ticks = r.timeout;
            e.switch_request = 1'b1;
            e.status = ST_QUEUED;
          end
        end
        FUNC_UNLOCK: begin
          if (held && owner == r.task_req) begin
            held = 1'b0;
            owner = '0;
            e.prio_write = 1'b1;
            e.prio_task = r.task_req;
            e.prio_value = r.base_priority;
            e.status = ST_RELEASED;
            for (int i = 0; i < TASKS; i++) begin
              if (waiting[i] && (!found || waiter_prio[i] < best_prio)) begin
                found = 1'b1;
                best = TASK_W'(i);
                best_prio = waiter_prio[i];
              end
            end
            if (found) begin
              waiting[best] = 1'b0;
              held = 1'b1;
              owner = best;
              owner_prio = best_prio;
              e.woken_valid = 1'b1;
              e.woken_task = best;
              e.switch_request = 1'b1;
              e.status = ST_HANDED;
            end
          end
        end
        FUNC_EXPIRE: begin
          if (waiting[r.task_req]) begin
            waiting[r.task_req] = 1'b0;
            e.status = ST_REMOVED;
          end else begin
            e.status = ST_NO_WAITER;
          end
        end
        default: ;
      endcase
      e.owner_valid = held;
      e.owner_now = held ? owner : '0;
      expected_q.push_back(e);
    endfunction

    function void compare(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: response with no request pending, actual %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      compare("status", e.status, got.status);
      compare("owner_valid", e.owner_valid, got.owner_valid);
      compare("owner_now", e.owner_now, got.owner_now);
      compare("prio_write", e.prio_write, got.prio_write);
      compare("prio_task", e.prio_task, got.prio_task);
      compare("prio_value", e.prio_value, got.prio_value);
      compare("woken_valid", e.woken_valid, got.woken_valid);
      compare("woken_task", e.woken_task, got.woken_task);
      compare("wait_ticks", e.wait_ticks, got.wait_ticks);
      compare("switch_request", e.switch_request, got.switch_request);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  bit   calm;
  int   quiet_cycles;

  mutex_scoreboard sb;

  priority_inheritance_mutex dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    calm = 1'b0;
    quiet_cycles = 0;
    sb = new();
  end

  always #5 clk = ~clk;

  // request and response monitor, plus watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_request(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_response(out_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // response side stalls in bursts
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  function automatic req_t make_req(logic [1:0] f, int tid, int rp, int bp,
                                    logic [31:0] tmo);
    req_t r;
    r.func = f;
    r.task_req = TASK_W'(tid);
    r.requester_priority = PRIO_W'(rp);
    r.base_priority = PRIO_W'(bp);
    r.timeout = tmo;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   sel;
    sel = $urandom_range(0, 99);
    r.task_req = TASK_W'($urandom_range(0, TASKS - 1));
    r.requester_priority = ($urandom_range(0, 19) == 0) ? 8'hFF : PRIO_W'($urandom_range(0, 254));
    r.base_priority = PRIO_W'($urandom_range(0, 255));
    r.timeout = $urandom;
    if (sel < 45) begin
      r.func = FUNC_LOCK;
      if ($urandom_range(0, 9) == 0) r.timeout = '0;
      else if ($urandom_range(0, 4) == 0) r.timeout = $urandom_range(1, 20);
    end else if (sel < 75) begin
      r.func = FUNC_UNLOCK;
      if (sb.held && $urandom_range(0, 99) < 85) r.task_req = sb.owner;
    end else if (sel < 95) begin
      r.func = FUNC_EXPIRE;
      if (sb.waiting != '0 && $urandom_range(0, 99) < 80) begin
        while (!sb.waiting[r.task_req]) r.task_req = TASK_W'($urandom_range(0, TASKS - 1));
      end
    end else begin
      r.func = FUNC_NONE;
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input req_t r);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    req_t directed [$];
    #1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // acquire, re-lock, refusal, boosts, ties, requeue, expiry, handover and release
    directed.push_back(make_req(FUNC_LOCK, 0, 200, 17, 32'd5));
    directed.push_back(make_req(FUNC_LOCK, 0, 3, 3, 32'd0));
    directed.push_back(make_req(FUNC_LOCK, 1, 100, 100, 32'd0));
    directed.push_back(make_req(FUNC_LOCK, 1, 100, 100, 32'hFFFF_FFFF));
    directed.push_back(make_req(FUNC_LOCK, 2, 150, 150, 32'd1));
    directed.push_back(make_req(FUNC_LOCK, 3, 100, 100, 32'd7));
    directed.push_back(make_req(FUNC_LOCK, 2, 50, 150, 32'd9));
    directed.push_back(make_req(FUNC_UNLOCK, 5, 0, 0, 32'd0));
    directed.push_back(make_req(FUNC_EXPIRE, 6, 0, 0, 32'd0));
    directed.push_back(make_req(FUNC_EXPIRE, 3, 0, 0, 32'd0));
    directed.push_back(make_req(FUNC_UNLOCK, 0, 0, 254, 32'd0));
    directed.push_back(make_req(FUNC_UNLOCK, 2, 0, 0, 32'd0));
    directed.push_back(make_req(FUNC_UNLOCK, 1, 0, 255, 32'd0));
    directed.push_back(make_req(FUNC_UNLOCK, 1, 0, 0, 32'd0));
    directed.push_back(make_req(FUNC_EXPIRE, 1, 0, 0, 32'd0));
    directed.push_back(make_req(FUNC_NONE, 7, 255, 255, 32'hFFFF_FFFF));
    // extreme priorities, handover to a waiter at 255
    directed.push_back(make_req(FUNC_LOCK, 7, 255, 255, 32'hFFFF_FFFF));
    directed.push_back(make_req(FUNC_LOCK, 4, 255, 255, 32'd3));
    directed.push_back(make_req(FUNC_LOCK, 5, 0, 0, 32'd1));
    directed.push_back(make_req(FUNC_LOCK, 6, 0, 0, 32'hAAAA_5555));
    directed.push_back(make_req(FUNC_UNLOCK, 7, 255, 255, 32'h5555_AAAA));
    directed.push_back(make_req(FUNC_UNLOCK, 5, 0, 0, 32'd0));
    directed.push_back(make_req(FUNC_UNLOCK, 6, 0, 0, 32'd0));
    directed.push_back(make_req(FUNC_UNLOCK, 4, 0, 128, 32'd0));
    directed.push_back(make_req(FUNC_LOCK, 3, 0, 0, 32'd0));

    foreach (directed[i]) send_request(directed[i]);
    drain();

    for (int n = directed.size(); n < ITEMS; n++) begin
      calm = (n >= 400 && n < 470) || n >= ITEMS - 120;
      if (n % 200 == 100) drain();
      send_request(random_req());
    end
    drain();
    repeat (SETTLE) @(negedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
